FILE: hw/rtl/handle_table_allocator_translator_defines.svh
// Assertion macros for the handle table.
`ifndef HANDLE_TABLE_ALLOCATOR_TRANSLATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define HTA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define HTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define HTA_ASSERT(label, clk, rst_n, prop, msg)

`define HTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/hta_pkg.sv
package hta_pkg;

    localparam int DEFAULT_ENTRIES = 4096;

    localparam int OP_W      = 3;
    localparam int PTR_W     = 64;
    localparam int SIZE_W    = 32;
    localparam int OFF_W     = 32;
    localparam int IDX_FLD_W = 31;
    localparam int STATUS_W  = 2;
    localparam int STAMP_W   = 64;
    localparam int LOCK_W    = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_BOUNDS_CHECK = 2'd0;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_REALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCK    = 3'd3;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOB  = 2'd2;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_REALLOC,
        K_FREE,
        K_LOCK,
        K_UNLOCK,
        K_OOB,
        K_PASS
    } kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_ISSUE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [PTR_W-1:0]   ptr;
        logic [SIZE_W-1:0]  size;
        logic [PTR_W-1:0]   backing;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

FILE: hw/rtl/hta_channels.sv
interface hta_req_if;
    logic                             valid;
    logic                             ready;
    logic [hta_pkg::OP_W-1:0]         op;
    logic [hta_pkg::PTR_W-1:0]        pointer_value;
    logic [hta_pkg::SIZE_W-1:0]       alloc_size;
    logic [hta_pkg::PTR_W-1:0]        backing_addr;

    modport source (output valid, op, pointer_value, alloc_size, backing_addr, input ready);
    modport sink (input valid, op, pointer_value, alloc_size, backing_addr, output ready);
endinterface

interface hta_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [hta_pkg::PTR_W-1:0]        result_value;
    logic [hta_pkg::STATUS_W-1:0]     status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

FILE: hw/rtl/hta_ram.sv
module hta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/hta_front.sv
module hta_front #(
    parameter int ENTRIES = hta_pkg::DEFAULT_ENTRIES
) (
    hta_req_if.sink              req,
    input  hta_pkg::back_status_t bstat,
    input  logic                 q_full,
    output logic                 push,
    output hta_pkg::cmd_t        push_cmd
);

    logic                            marked;
    logic [hta_pkg::IDX_FLD_W-1:0]   idx;
    logic                            in_range;
    hta_pkg::kind_t                  kind;

    assign marked   = req.pointer_value[hta_pkg::PTR_W-1];
    assign idx      = req.pointer_value[hta_pkg::OFF_W +: hta_pkg::IDX_FLD_W];
    assign in_range = idx < hta_pkg::IDX_FLD_W'(ENTRIES);

    always_comb
    begin
        case (req.op)
            hta_pkg::OP_ALLOC:   kind = hta_pkg::K_ALLOC;
            hta_pkg::OP_REALLOC: kind = in_range ? hta_pkg::K_REALLOC : hta_pkg::K_PASS;
            hta_pkg::OP_FREE:    kind = in_range ? hta_pkg::K_FREE : hta_pkg::K_PASS;
            hta_pkg::OP_LOCK:
            begin
                if (!marked)
                    kind = hta_pkg::K_PASS;
                else if (in_range)
                    kind = hta_pkg::K_LOCK;
                else
                    kind = hta_pkg::K_OOB;
            end
            hta_pkg::OP_UNLOCK:
                kind = (marked && in_range) ? hta_pkg::K_UNLOCK : hta_pkg::K_PASS;
            default: kind = hta_pkg::K_PASS;
        endcase
    end

    assign req.ready        = !q_full && !bstat.clearing;
    assign push             = req.valid && req.ready;
    assign push_cmd.kind    = kind;
    assign push_cmd.ptr     = req.pointer_value;
    assign push_cmd.size    = req.alloc_size;
    assign push_cmd.backing = req.backing_addr;

endmodule

FILE: hw/rtl/hta_queue.sv
`include "handle_table_allocator_translator_defines.svh"

module hta_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hta_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output hta_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = hta_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hta_pkg::cmd_t    slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    `HTA_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count over depth")
    `HTA_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")

endmodule

FILE: hw/rtl/hta_back.sv
`include "handle_table_allocator_translator_defines.svh"

module hta_back #(
    parameter int ENTRIES = hta_pkg::DEFAULT_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  bounds_check_enable,
    input  logic                  q_valid,
    input  hta_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    output hta_pkg::back_status_t bstat,
    hta_rsp_if.source             rsp
);

    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int LINK_W    = $clog2(ENTRIES + 1);
    localparam int PTR_W     = hta_pkg::PTR_W;
    localparam int SIZE_W    = hta_pkg::SIZE_W;
    localparam int OFF_W     = hta_pkg::OFF_W;
    localparam int LOCK_W    = hta_pkg::LOCK_W;
    localparam int STAMP_W   = hta_pkg::STAMP_W;
    localparam int STAMP_LSB = LINK_W;
    localparam int LOCK_LSB  = STAMP_LSB + STAMP_W;
    localparam int SIZE_LSB  = LOCK_LSB + LOCK_W;
    localparam int BACK_LSB  = SIZE_LSB + SIZE_W;
    localparam int ROW_W     = BACK_LSB + PTR_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRIES);

    hta_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [STAMP_W-1:0]   usage_reg, usage_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    hta_pkg::cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [PTR_W-1:0]     rsp_value_reg, rsp_value_next;
    logic [hta_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ROW_W-1:0]     rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ROW_W-1:0]     wr_data;

    logic [LINK_W-1:0]    r_link;
    logic [STAMP_W-1:0]   r_stamp;
    logic [LOCK_W-1:0]    r_lock;
    logic [SIZE_W-1:0]    r_size;
    logic [PTR_W-1:0]     r_back;
    logic [OFF_W-1:0]     off;
    logic                 out_free;

    hta_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign r_link   = rd_data[0 +: LINK_W];
    assign r_stamp  = rd_data[STAMP_LSB +: STAMP_W];
    assign r_lock   = rd_data[LOCK_LSB +: LOCK_W];
    assign r_size   = rd_data[SIZE_LSB +: SIZE_W];
    assign r_back   = rd_data[BACK_LSB +: PTR_W];
    assign off      = cmd_reg.ptr[OFF_W-1:0];
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        usage_next      = usage_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = rd_data;

        case (state_reg)
            hta_pkg::BK_CLEAR:
            begin
                // initial free list: each entry links to the next
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = {PTR_W'(0), SIZE_W'(0), LOCK_W'(0), STAMP_W'(0),
                           LINK_W'(clr_cnt_reg) + LINK_W'(1)};
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1))
                    state_next = hta_pkg::BK_ISSUE;
                else
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            hta_pkg::BK_ISSUE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    rd_en    = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.kind == hta_pkg::K_ALLOC)
                        rd_addr = head_reg[IDX_W-1:0];
                    else
                        rd_addr = q_cmd.ptr[OFF_W +: IDX_W];
                    addr_next  = rd_addr;
                    state_next = hta_pkg::BK_EXEC;
                end
            end
            hta_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = cmd_reg.ptr;
                    rsp_status_next = hta_pkg::ST_OK;
                    state_next      = hta_pkg::BK_ISSUE;
                    case (cmd_reg.kind)
                        hta_pkg::K_ALLOC:
                        begin
                            if (head_reg == LINK_NONE)
                            begin
                                rsp_value_next  = '0;
                                rsp_status_next = hta_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_data   = {cmd_reg.backing, cmd_reg.size, LOCK_W'(0),
                                             STAMP_W'(0), r_link};
                                head_next = r_link;
                                rsp_value_next = {1'b1, hta_pkg::IDX_FLD_W'(head_reg),
                                                  OFF_W'(0)};
                            end
                        end
                        hta_pkg::K_REALLOC:
                        begin
                            wr_en   = 1'b1;
                            wr_data = {cmd_reg.backing, cmd_reg.size, r_lock, r_stamp, r_link};
                        end
                        hta_pkg::K_FREE:
                        begin
                            wr_en     = 1'b1;
                            wr_data   = {PTR_W'(0), SIZE_W'(0), LOCK_W'(0), STAMP_W'(0),
                                         head_reg};
                            head_next = LINK_W'(addr_reg);
                        end
                        hta_pkg::K_LOCK:
                        begin
                            if (bounds_check_enable && off >= r_size)
                            begin
                                rsp_value_next  = '0;
                                rsp_status_next = hta_pkg::ST_OOB;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = {r_back, r_size, r_lock + LOCK_W'(1),
                                              usage_reg, r_link};
                                usage_next = usage_reg + STAMP_W'(1);
                                rsp_value_next = r_back | PTR_W'(off);
                            end
                        end
                        hta_pkg::K_UNLOCK:
                        begin
                            wr_en   = 1'b1;
                            wr_data = {r_back, r_size, r_lock - LOCK_W'(1), r_stamp, r_link};
                        end
                        hta_pkg::K_OOB:
                        begin
                            rsp_value_next  = '0;
                            rsp_status_next = hta_pkg::ST_OOB;
                        end
                        default:
                        begin
                            rsp_status_next = hta_pkg::ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = hta_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hta_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            usage_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            usage_reg     <= usage_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign bstat.clearing   = state_reg == hta_pkg::BK_CLEAR;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;

    `HTA_ASSERT_IMPL(a_exec_after_issue, clk, rst_n, state_reg == hta_pkg::BK_EXEC, $past(state_reg) == hta_pkg::BK_ISSUE || $past(state_reg) == hta_pkg::BK_EXEC, "exec entered without issue")
    `HTA_ASSERT(a_head_range, clk, rst_n, head_reg <= LINK_NONE, "free head beyond table")
    `HTA_ASSERT_IMPL(a_write_phase, clk, rst_n, wr_en, state_reg == hta_pkg::BK_CLEAR || (state_reg == hta_pkg::BK_EXEC && out_free), "table written outside clear or execute")

endmodule

FILE: hw/rtl/handle_table_allocator_translator.sv
// Channel  Dir  Payload                                        Handshake
// req      in   op, pointer_value, alloc_size, backing_addr    valid/ready
// rsp      out  result_value, status                           valid/ready
// apb      in   paddr, pwdata -> bounds_check_enable          psel/penable/pwrite
//
// Each transaction: a table row read, then the row write and result.
// After reset the table is swept once, building the free list; req.ready
// stays low during the sweep.
// A two-entry command queue separates decode from execution; a held result
// stalls execution only, not acceptance into the queue.
`include "handle_table_allocator_translator_defines.svh"

module handle_table_allocator_translator #(
    parameter int ENTRIES = hta_pkg::DEFAULT_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    hta_req_if.sink                          req,
    hta_rsp_if.source                        rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hta_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hta_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hta_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic                  bce_reg;
    logic                  cfg_wr;
    hta_pkg::back_status_t bstat;
    logic                  q_full;
    logic                  q_push;
    hta_pkg::cmd_t         q_push_cmd;
    logic                  q_pop;
    logic                  q_valid;
    hta_pkg::cmd_t         q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == hta_pkg::ADDR_BOUNDS_CHECK);
    assign prdata = (paddr == hta_pkg::ADDR_BOUNDS_CHECK)
                    ? {(hta_pkg::CFG_DATA_W - 1)'(0), bce_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bce_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            bce_reg <= pwdata[0];
        end
    end

    hta_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .req      (req),
        .bstat    (bstat),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    hta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (q_cmd)
    );

    hta_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .bounds_check_enable (bce_reg),
        .q_valid             (q_valid),
        .q_cmd               (q_cmd),
        .q_pop               (q_pop),
        .bstat               (bstat),
        .rsp                 (rsp)
    );

endmodule
